// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define DIF_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define DIF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/dif_pkg.sv =====
// Package for the delimited integer field parser: types, codes, widths.
// Depends on nothing.
package dif_pkg;

    localparam int BYTE_W = 8;
    localparam int ACC_W  = 60;
    localparam int VAL_W  = 61;
    localparam int CNT_W  = 5;
    localparam int PH_W   = 3;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [PH_W-1:0] PH_LEAD = 3'd0;
    localparam logic [PH_W-1:0] PH_NUM  = 3'd1;
    localparam logic [PH_W-1:0] PH_N    = 3'd2;
    localparam logic [PH_W-1:0] PH_NA   = 3'd3;
    localparam logic [PH_W-1:0] PH_BAD  = 3'd4;

    localparam logic [1:0] ST_VALID = 2'd0;
    localparam logic [1:0] ST_NA    = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic [1:0] END_SEP = 2'd0;
    localparam logic [1:0] END_EOL = 2'd1;
    localparam logic [1:0] END_EOI = 2'd2;

    localparam logic REG_SEP = 1'b0;
    localparam logic REG_EOL = 1'b1;

    localparam logic [BYTE_W-1:0] SEP_RESET = 8'd44;
    localparam logic [BYTE_W-1:0] EOL_RESET = 8'd10;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_N     = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;

    localparam logic [ACC_W-1:0] FIT_POS_MAX = 60'd2147483647;
    localparam logic [ACC_W-1:0] FIT_NEG_MAX = 60'd2147483648;

    typedef struct packed {
        logic [BYTE_W-1:0] sep;
        logic [BYTE_W-1:0] eol;
    } dif_cfg_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [1:0]              status;
        logic                    fits;
        logic [1:0]              ended_by;
    } dif_result_t;

endpackage

// ===== src/delimited_integer_field_parser.sv =====
// Top level of the delimited integer field parser.
// Depends on dif_pkg, dif_apb_regs, dif_parser, dif_out_reg.
//
// Usage:
//   Input channel (s_*): one text byte per request, or an end marker that
//   closes the current field. Output channel (m_*): one request per field
//   end, carrying value, status, 32-bit fit flag and terminator kind.
//   APB port: separator byte at 0x0, line end byte at 0x4; write only
//   while idle. pready is tied high.
//   A terminating byte passes through the input register, then the result
//   register, before its result shows on m_*.
//   Throughput: one byte per cycle unless m_* stalls, set by the single
//   multiply-by-ten-add step between the input register and parser state.
//   Stall: while a result waits on m_ready, one more byte is taken into
//   the input register; then s_ready drops until the result is taken.
//   Reset: synchronous, active low; clears the parser state, both
//   channels and sets separator to ',' and line end to LF.
module delimited_integer_field_parser
    import dif_pkg::*;
#(
    parameter int MAX_FIELD_CHARS = 18
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [BYTE_W-1:0]       s_text_byte,
    input  logic                    s_end_marker,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_field_value,
    output logic [1:0]              m_field_status,
    output logic                    m_fits_32,
    output logic [1:0]              m_ended_by
);

    dif_cfg_t          cfg;
    dif_result_t       res, out_data;
    logic              has_result, advance;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_end_reg;

    dif_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_end_reg  <= s_end_marker;
        end
    end

    dif_parser #(
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .step       (advance),
        .text_byte  (in_byte_reg),
        .end_marker (in_end_reg),
        .has_result (has_result),
        .result     (res)
    );

    dif_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && has_result),
        .load_data (res),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (out_data)
    );

    assign m_field_value  = out_data.value;
    assign m_field_status = out_data.status;
    assign m_fits_32      = out_data.fits;
    assign m_ended_by     = out_data.ended_by;

endmodule

// ===== src/dif_apb_regs.sv =====
// APB-style register file holding the separator and line end bytes.
// Depends on dif_pkg.
module dif_apb_regs
    import dif_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output dif_cfg_t          cfg
);

    logic [BYTE_W-1:0] sep_reg, sep_next;
    logic [BYTE_W-1:0] eol_reg, eol_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        sep_next = sep_reg;
        eol_next = eol_reg;
        if (wr_en) begin
            case (paddr[2])
                REG_SEP: sep_next = pwdata[BYTE_W-1:0];
                REG_EOL: eol_next = pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg <= SEP_RESET;
            eol_reg <= EOL_RESET;
        end else begin
            sep_reg <= sep_next;
            eol_reg <= eol_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SEP: prdata = {{(DATA_W-BYTE_W){1'b0}}, sep_reg};
            REG_EOL: prdata = {{(DATA_W-BYTE_W){1'b0}}, eol_reg};
            default: prdata = '0;
        endcase
    end

    assign cfg.sep = sep_reg;
    assign cfg.eol = eol_reg;

endmodule

// ===== src/dif_parser.sv =====
// Field parser state and per-byte next-state / result logic.
// Depends on dif_pkg.
module dif_parser
    import dif_pkg::*;
#(
    parameter int MAX_FIELD_CHARS = 18
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dif_cfg_t          cfg,
    input  logic              step,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              end_marker,
    output logic              has_result,
    output dif_result_t       result
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FIELD_CHARS);
    localparam logic [CNT_W-1:0] SAT_CNT = CNT_W'(MAX_FIELD_CHARS + 1);

    logic [PH_W-1:0]  phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             is_sep, is_eol, is_blank, is_sign, is_digit;
    logic [3:0]       digit;
    logic [ACC_W-1:0] acc_mac;
    logic [VAL_W-1:0] mag;

    assign is_sep   = (text_byte == cfg.sep);
    assign is_eol   = (text_byte == cfg.eol);
    assign is_blank = (text_byte == CH_SPACE) ||
                      (text_byte >= CH_TAB && text_byte <= CH_CR);
    assign is_sign  = (text_byte == CH_PLUS) || (text_byte == CH_MINUS);
    assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    assign digit    = text_byte[3:0];
    assign acc_mac  = (acc_reg << 3) + (acc_reg << 1) + ACC_W'(digit);
    assign mag      = {1'b0, acc_reg};

    assign has_result = end_marker || is_sep || is_eol;

    always_comb begin
        result.value    = '0;
        result.fits     = 1'b0;
        result.status   = ST_BAD;
        result.ended_by = end_marker ? END_EOI : (is_sep ? END_SEP : END_EOL);
        if (phase_reg == PH_LEAD || phase_reg == PH_NA) begin
            result.status = ST_NA;
        end else if (phase_reg == PH_NUM && cnt_reg != '0 && cnt_reg <= MAX_CNT) begin
            result.status = ST_VALID;
            if (neg_reg) begin
                result.value = -$signed(mag);
                result.fits  = (acc_reg <= FIT_NEG_MAX);
            end else begin
                result.value = $signed(mag);
                result.fits  = (acc_reg <= FIT_POS_MAX);
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        if (has_result) begin
            phase_next = PH_LEAD;
            neg_next   = 1'b0;
            acc_next   = '0;
            cnt_next   = '0;
        end else begin
            case (phase_reg)
                PH_LEAD: begin
                    if (is_blank) begin
                        phase_next = PH_LEAD;
                    end else if (is_sign) begin
                        neg_next   = (text_byte == CH_MINUS);
                        cnt_next   = CNT_W'(1);
                        phase_next = PH_NUM;
                    end else if (is_digit) begin
                        acc_next   = ACC_W'(digit);
                        cnt_next   = CNT_W'(1);
                        phase_next = PH_NUM;
                    end else if (text_byte == CH_N) begin
                        phase_next = PH_N;
                    end else begin
                        phase_next = PH_BAD;
                    end
                end
                PH_NUM: begin
                    if (is_digit) begin
                        if (cnt_reg < MAX_CNT) begin
                            acc_next = acc_mac;
                        end
                        if (cnt_reg < SAT_CNT) begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end else begin
                        phase_next = PH_BAD;
                    end
                end
                PH_N: begin
                    phase_next = (text_byte == CH_A) ? PH_NA : PH_BAD;
                end
                default: begin
                    phase_next = PH_BAD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== src/dif_out_reg.sv =====
// Result register of the parser: holds one finished request for the sink.
// Depends on dif_pkg.
module dif_out_reg
    import dif_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  dif_result_t load_data,
    input  logic        m_ready,
    output logic        m_valid,
    output dif_result_t m_data
);

    logic        valid_reg, valid_next;
    dif_result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== src/dif_checker.sv =====
// Port-level checker for the delimited integer field parser, with its bind.
// Depends on dif_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dif_checker
    import dif_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [VAL_W-1:0] m_field_value,
    input  logic [1:0]              m_field_status,
    input  logic                    m_fits_32,
    input  logic [1:0]              m_ended_by
);

    `DIF_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_field_value) && $stable(m_field_status) && $stable(m_ended_by), "result request changed while stalled")
    `DIF_ASSERT(a_not_valid_zero, aclk, aresetn, m_valid && m_field_status != ST_VALID |-> m_field_value == '0 && !m_fits_32, "non-valid field carries value or fit flag")
    `DIF_ASSERT(a_codes, aclk, aresetn, m_valid |-> m_field_status != 2'd3 && m_ended_by != 2'd3, "undefined status or terminator code")
    `DIF_ASSERT(a_stall_input, aclk, aresetn, m_valid && !m_ready && !s_ready |=> !s_ready || m_ready || !m_valid, "input taken with both stages full")
    `DIF_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind delimited_integer_field_parser dif_checker u_dif_checker (.*);

// ===== bench/delimited_integer_field_parser_test.sv =====
// Testbench for delimited_integer_field_parser: directed and random text, checked field by field.
// Depends on dif_pkg and the delimited_integer_field_parser RTL.
// Holds its own parser model in a scoreboard class and drives the block through plain tasks.
module delimited_integer_field_parser_test;
    import dif_pkg::*;

    localparam int MAX_CHARS      = 18;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_BYTES    = 70;
    localparam int NUM_PHASES     = 7;
    localparam int REPORT_LIMIT   = 10;

    class field_result_checker;
        logic [BYTE_W-1:0] sep;
        logic [BYTE_W-1:0] eol;
        logic [PH_W-1:0]   phase;
        logic              neg;
        logic [ACC_W-1:0]  acc;
        int unsigned       nchars;
        dif_result_t       pending_fields[$];
        int unsigned       failures;

        function new();
            sep = SEP_RESET;
            eol = EOL_RESET;
            failures = 0;
            clear_field();
        endfunction

        function void clear_field();
            phase = PH_LEAD;
            neg = 1'b0;
            acc = '0;
            nchars = 0;
        endfunction

        function void set_register(logic idx, logic [BYTE_W-1:0] v);
            if (idx == REG_SEP) begin
                sep = v;
            end else begin
                eol = v;
            end
        endfunction

        function void close_field(logic [1:0] how);
            dif_result_t r;
            r.value = '0;
            r.fits = 1'b0;
            r.ended_by = how;
            if (phase == PH_LEAD || phase == PH_NA) begin
                r.status = ST_NA;
            end else if (phase == PH_NUM && nchars >= 1 && nchars <= MAX_CHARS) begin
                r.status = ST_VALID;
                if (neg) begin
                    r.value = -$signed({1'b0, acc});
                    r.fits = (acc <= FIT_NEG_MAX);
                end else begin
                    r.value = $signed({1'b0, acc});
                    r.fits = (acc <= FIT_POS_MAX);
                end
            end else begin
                r.status = ST_BAD;
            end
            pending_fields.push_back(r);
            clear_field();
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b, logic em);
            logic is_digit;
            logic is_blank;
            is_digit = (b >= CH_ZERO && b <= CH_NINE);
            is_blank = (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR));
            if (em) begin
                close_field(END_EOI);
            end else if (b == sep) begin
                close_field(END_SEP);
            end else if (b == eol) begin
                close_field(END_EOL);
            end else begin
                case (phase)
                    PH_LEAD: begin
                        if (!is_blank) begin
                            if (b == CH_PLUS || b == CH_MINUS) begin
                                neg = (b == CH_MINUS);
                                nchars = 1;
                                phase = PH_NUM;
                            end else if (is_digit) begin
                                acc = ACC_W'(b - CH_ZERO);
                                nchars = 1;
                                phase = PH_NUM;
                            end else if (b == CH_N) begin
                                phase = PH_N;
                            end else begin
                                phase = PH_BAD;
                            end
                        end
                    end
                    PH_NUM: begin
                        if (is_digit) begin
                            if (nchars < MAX_CHARS)
                                acc = acc * 10 + ACC_W'(b - CH_ZERO);
                            if (nchars < MAX_CHARS + 1)
                                nchars++;
                        end else begin
                            phase = PH_BAD;
                        end
                    end
                    PH_N: phase = (b == CH_A) ? PH_NA : PH_BAD;
                    default: phase = PH_BAD;
                endcase
            end
        endfunction

        function void check_field(logic signed [VAL_W-1:0] v, logic [1:0] st, logic f,
                                  logic [1:0] eb);
            dif_result_t want;
            if (pending_fields.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected field: value %0d status %0d fits %0d end %0d",
                             v, st, f, eb);
                return;
            end
            want = pending_fields.pop_front();
            if (want.value !== v || want.status !== st || want.fits !== f ||
                want.ended_by !== eb) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("field mismatch: expected value %0d status %0d fits %0d end %0d, %s",
                             want.value, want.status, want.fits, want.ended_by,
                             $sformatf("got value %0d status %0d fits %0d end %0d",
                                       v, st, f, eb));
            end
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    s_valid;
    logic                    s_ready;
    logic [BYTE_W-1:0]       s_text_byte;
    logic                    s_end_marker;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [VAL_W-1:0] m_field_value;
    logic [1:0]              m_field_status;
    logic                    m_fits_32;
    logic [1:0]              m_ended_by;

    field_result_checker sb;
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          quiet_cycles = 0;
    int unsigned ready_tick = 0;
    int          stall_left = 0;
    logic [BYTE_W-1:0] sep_plan [1:NUM_PHASES-1] = '{8'h3B, 8'h00, 8'hFF, 8'h7C, CH_MINUS, 8'h00};
    logic [BYTE_W-1:0] eol_plan [1:NUM_PHASES-1] = '{CH_CR, 8'hFF, 8'h00, 8'h7C, 8'h37, 8'h00};

    delimited_integer_field_parser #(
        .MAX_FIELD_CHARS(MAX_CHARS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_marker  (s_end_marker),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_field_value (m_field_value),
        .m_field_status(m_field_status),
        .m_fits_32     (m_fits_32),
        .m_ended_by    (m_ended_by)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side stall pattern: always ready, mostly ready, occasional long stalls, then alternating ready
    always @(posedge aclk) begin
        ready_tick++;
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            case ((ready_tick / 128) % 4)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(4, 20);
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                    end
                end
                default: m_ready <= ready_tick[0];
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            quiet_cycles++;
            if (s_valid && s_ready) begin
                sb.take_byte(s_text_byte, s_end_marker);
                quiet_cycles = 0;
            end
            if (m_valid && m_ready) begin
                sb.check_field(m_field_value, m_field_status, m_fits_32, m_ended_by);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic em);
        int gap;
        s_valid <= 1'b1;
        s_text_byte <= b;
        s_end_marker <= em;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 32);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_end();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic apb_write(input logic idx, input logic [BYTE_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {{(DATA_W-BYTE_W){1'b0}}, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_register(idx, v);
        @(posedge aclk);
    endtask

    // hold the sender until every field result is back, then let the pipe empty
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending_fields.size() != 0)
            @(negedge aclk);
        @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_field();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            n = $urandom_range(0, 2);
            repeat (n) begin
                if ($urandom_range(0, 1) == 0)
                    send_byte(CH_SPACE, 1'b0);
                else
                    send_byte(CH_TAB + 8'($urandom_range(0, 4)), 1'b0);
            end
            case ($urandom_range(0, 3))
                0: send_byte(CH_MINUS, 1'b0);
                1: send_byte(CH_PLUS, 1'b0);
                default: ;
            endcase
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 21) : $urandom_range(1, 10);
            if ($urandom_range(0, 19) == 0)
                n = 0;
            repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            if ($urandom_range(0, 9) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (kind < 80) begin
            if ($urandom_range(0, 1) == 0)
                send_byte(CH_SPACE, 1'b0);
            send_byte(CH_N, 1'b0);
            if ($urandom_range(0, 3) != 0)
                send_byte(CH_A, 1'b0);
            if ($urandom_range(0, 4) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (kind < 88) begin
            repeat ($urandom_range(0, 2)) send_byte(CH_SPACE, 1'b0);
        end else begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        case ($urandom_range(0, 9))
            0: send_end();
            1, 2: send_byte(sb.eol, 1'b0);
            default: send_byte(sb.sep, 1'b0);
        endcase
    endtask

    initial begin
        int start;
        sb = new();
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_valid <= 1'b0;
        s_text_byte <= '0;
        s_end_marker <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_text("0,");
        send_text("+2147483647,");
        send_text("-2147483648,");
        send_text("2147483648,");
        send_text("-2147483649\n");
        send_text(" \t-0,");
        send_text("-,");
        send_text("+\n");
        send_text("NA,");
        send_text("  NA\n");
        send_text("N,");
        send_text("NAx,");
        send_text("-NA,");
        send_text("1NA,");
        send_text("12 ,");
        send_text("1-2,");
        send_text("+-3,");
        send_text(",\n");
        send_text("999999999999999999,");
        send_text("-999999999999999999,");
        send_text("1234567890123456789,");
        send_text("0000000000000000000000012,");
        send_byte(8'h00, 1'b0);
        send_text(",x");
        send_byte(8'hFF, 1'b0);
        send_text("\n7");
        send_byte(8'h2C, 1'b1);
        send_end();
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                if (ph == NUM_PHASES - 1) begin
                    apb_write(REG_SEP, 8'($urandom_range(0, 255)));
                    apb_write(REG_EOL, 8'($urandom_range(0, 255)));
                end else begin
                    apb_write(REG_SEP, sep_plan[ph]);
                    apb_write(REG_EOL, eol_plan[ph]);
                end
            end
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                send_random_field();
            drain();
        end

        @(negedge aclk);
        if (sb.failures == 0 && sb.pending_fields.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
